// ===== rtl/core/fmc_pkg.sv =====
// Shared types, constants and the quarter-wave sine table generator for the FM oscillator.
package fmc_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int INC_W       = 32;
    localparam int INDEX_W     = 22;
    localparam int GAIN_W      = 16;
    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = 15;
    localparam int SINE_W      = 16;
    localparam int MUL_A_W     = 23;
    localparam int PROD_W      = MUL_A_W + SINE_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_INC = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTER_INC   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INNER_INC   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTER_INDEX = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INNER_INDEX = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_GAIN = 3'd5;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [INC_W-1:0]   carrier_increment;
        logic [INC_W-1:0]   outer_mod_increment;
        logic [INC_W-1:0]   inner_mod_increment;
        logic [INDEX_W-1:0] outer_index;
        logic [INDEX_W-1:0] inner_index;
        logic [GAIN_W-1:0]  output_gain;
    } fmc_cfg_t;

    typedef struct packed {
        logic valid;
        logic note_start;
    } fmc_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_INNER,
        ST_MUL_INNER,
        ST_RD_OUTER,
        ST_MUL_OUTER,
        ST_RD_CARR,
        ST_MUL_GAIN,
        ST_FINISH
    } fmc_state_t;

    // Elaboration-time only: restoring shift-subtract quotient, truncating.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Elaboration-time only: round(32767*sin(pi/2*k/2^addr_bits)) by integer Taylor series.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned addr_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] denom;
        longint      sum;
        longint      v;
        x    = (64'(k) * HALF_PI_Q30) >> addr_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            denom = 64'((2 * n) * (2 * n + 1));
            term  = udiv64((term * x2) >> 30, denom);
            if ((n & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
        if (v > 32767)
            v = 32767;
        return v[MAG_W-1:0];
    endfunction

endpackage

// ===== rtl/core/fmc_front.sv =====
// Input side: accepts sample ticks into a two-entry queue ahead of the engine.
module fmc_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             note_start,
    input  logic             pop,
    output fmc_pkg::fmc_req_t req
);
    import fmc_pkg::*;

    logic       note_q_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       do_pop;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != 2'd0);

    assign req.valid      = (count_reg != 2'd0);
    assign req.note_start = note_q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            note_q_reg[wr_ptr_reg] <= note_start;
    end

endmodule

// ===== rtl/core/fmc_sine_rom.sv =====
// Quarter-wave sine table, 2^ADDR_BITS+1 entries, registered read.
module fmc_sine_rom
#(
    parameter int ADDR_BITS = 10
)
(
    input  logic                        clk,
    input  logic [ADDR_BITS:0]          addr,
    output logic [fmc_pkg::MAG_W-1:0]   data
);
    import fmc_pkg::*;

    localparam int DEPTH = (1 << ADDR_BITS) + 1;

    logic [MAG_W-1:0] tab [0:DEPTH-1];
    logic [MAG_W-1:0] data_reg;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_tab
        localparam logic [MAG_W-1:0] ENTRY = quarter_sine(g, ADDR_BITS);
        assign tab[g] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= tab[addr];
    end

    assign data = data_reg;

endmodule

// ===== rtl/core/fmc_engine.sv =====
// Back end: phase accumulators, shared table lookup and multiplier, output register.
module fmc_engine
#(
    parameter int PHASE_BITS = 32,
    parameter int ADDR_BITS  = 10
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  fmc_pkg::fmc_cfg_t                 cfg,
    input  fmc_pkg::fmc_req_t                 req,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [fmc_pkg::SAMPLE_W-1:0] sample_out
);
    import fmc_pkg::*;

    localparam int INC_UP = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
    localparam int INC_DN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
    localparam int OFS_UP = (PHASE_BITS >= 31) ? PHASE_BITS - 31 : 0;
    localparam int OFS_DN = (PHASE_BITS < 31) ? 31 - PHASE_BITS : 0;
    localparam int INC_EXT_W = PHASE_BITS + INC_W;
    localparam int OFS_EXT_W = PHASE_BITS + PROD_W;
    localparam logic [ADDR_BITS:0] QUARTER = {1'b1, {ADDR_BITS{1'b0}}};

    fmc_state_t                state_reg;
    fmc_state_t                state_next;

    logic [PHASE_BITS-1:0]     carrier_reg;
    logic [PHASE_BITS-1:0]     carrier_next;
    logic [PHASE_BITS-1:0]     outer_reg;
    logic [PHASE_BITS-1:0]     outer_next;
    logic [PHASE_BITS-1:0]     inner_reg;
    logic [PHASE_BITS-1:0]     inner_next;

    logic signed [PROD_W-1:0]  prod_reg;
    logic [1:0]                quad_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic [PHASE_BITS-1:0]     offset;
    logic [PHASE_BITS-1:0]     arg;
    logic [ADDR_BITS+1:0]      lut_top;
    logic [1:0]                quad;
    logic [ADDR_BITS-1:0]      lut_k;
    logic [ADDR_BITS:0]        rom_addr;
    logic [MAG_W-1:0]          rom_data;
    logic signed [SINE_W-1:0]  sine;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W:0]    rounded;
    logic signed [PROD_W-16:0] shifted;
    logic signed [SAMPLE_W-1:0] sample_sat;
    logic                      load_out;
    logic                      out_fire;

    function automatic logic [PHASE_BITS-1:0] scale_inc(input logic [INC_W-1:0] inc);
        logic [INC_EXT_W-1:0] w;
        w = INC_EXT_W'(inc);
        w = (w << INC_UP) >> INC_DN;
        return w[PHASE_BITS-1:0];
    endfunction

    // index*sine is turns*2^31; move to phase units (floor on right shift)
    always_comb
    begin
        logic signed [OFS_EXT_W-1:0] e;
        e      = OFS_EXT_W'(prod_reg);
        e      = (e <<< OFS_UP) >>> OFS_DN;
        offset = e[PHASE_BITS-1:0];
    end

    always_comb
    begin
        case (state_reg)
            ST_RD_INNER: arg = inner_reg;
            ST_RD_OUTER: arg = outer_reg + offset;
            ST_RD_CARR:  arg = carrier_reg + offset;
            default:     arg = inner_reg;
        endcase
    end

    assign lut_top  = arg[PHASE_BITS-1 -: ADDR_BITS+2];
    assign quad     = lut_top[ADDR_BITS+1:ADDR_BITS];
    assign lut_k    = lut_top[ADDR_BITS-1:0];
    assign rom_addr = quad[0] ? (QUARTER - {1'b0, lut_k}) : {1'b0, lut_k};

    fmc_sine_rom #(.ADDR_BITS(ADDR_BITS)) u_rom
    (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign sine = quad_reg[1] ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

    always_comb
    begin
        case (state_reg)
            ST_MUL_INNER: mul_a = $signed({1'b0, cfg.inner_index});
            ST_MUL_OUTER: mul_a = $signed({1'b0, cfg.outer_index});
            ST_MUL_GAIN:  mul_a = $signed(MUL_A_W'(cfg.output_gain));
            default:      mul_a = '0;
        endcase
    end

    assign prod = mul_a * sine;

    // (gain*sine + 2^15) >> 16 with floor, then clamp
    always_comb
    begin
        rounded = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(32768);
        shifted = rounded[PROD_W:16];
        if (shifted > (PROD_W - 15)'(32767))
            sample_sat = 16'sh7fff;
        else if (shifted < -(PROD_W - 15)'(32768))
            sample_sat = -16'sh8000;
        else
            sample_sat = shifted[SAMPLE_W-1:0];
    end

    assign out_fire = out_valid_reg && !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        pop            = 1'b0;
        load_out       = 1'b0;
        carrier_next   = carrier_reg;
        outer_next     = outer_reg;
        inner_next     = inner_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    pop        = 1'b1;
                    state_next = ST_RD_INNER;
                    if (req.note_start)
                    begin
                        carrier_next = '0;
                        outer_next   = '0;
                        inner_next   = '0;
                    end
                end
            end
            ST_RD_INNER:  state_next = ST_MUL_INNER;
            ST_MUL_INNER: state_next = ST_RD_OUTER;
            ST_RD_OUTER:  state_next = ST_MUL_OUTER;
            ST_MUL_OUTER: state_next = ST_RD_CARR;
            ST_RD_CARR:   state_next = ST_MUL_GAIN;
            ST_MUL_GAIN:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out     = 1'b1;
                    state_next   = ST_IDLE;
                    carrier_next = carrier_reg + scale_inc(cfg.carrier_increment);
                    outer_next   = outer_reg + scale_inc(cfg.outer_mod_increment);
                    inner_next   = inner_reg + scale_inc(cfg.inner_mod_increment);
                end
            end
            default: state_next = ST_IDLE;
        endcase
        out_valid_next = load_out ? 1'b1 : (out_fire ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            carrier_reg   <= '0;
            outer_reg     <= '0;
            inner_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            carrier_reg   <= carrier_next;
            outer_reg     <= outer_next;
            inner_reg     <= inner_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD_INNER || state_reg == ST_RD_OUTER || state_reg == ST_RD_CARR)
            quad_reg <= quad;
        if (state_reg == ST_MUL_INNER || state_reg == ST_MUL_OUTER || state_reg == ST_MUL_GAIN)
            prod_reg <= prod;
        if (load_out)
            sample_reg <= sample_sat;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;

endmodule

// ===== rtl/core/fm_cascade_three_operator_osc.sv =====
// Three-operator cascade FM oscillator top level with its configuration registers.
//
//   channel   signals                          direction
//   input     in_valid, in_stall, note_start   tick in, stall out
//   output    out_valid, out_stall, sample_out sample out, stall in
//   config    cfg_write, cfg_index, cfg_data   register writes, no read-back
//
// Each tick passes through the engine in steps: three table lookups and three products
// through one sine table and one multiplier, then the output load.
// Ticks queue two deep ahead of the engine; in_stall rises when the queue is full.
// A held output stalls the engine in its final step until the transfer completes.
// Reset clears the phases, state, queue and config; no clearing pass is needed.
module fm_cascade_three_operator_osc
#(
    parameter int PHASE_BITS           = 32,
    parameter int SINE_TABLE_ADDR_BITS = 10
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   note_start,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [fmc_pkg::SAMPLE_W-1:0]    sample_out,
    input  logic                                   cfg_write,
    input  logic [fmc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [fmc_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import fmc_pkg::*;

    fmc_cfg_t cfg_reg;
    fmc_cfg_t cfg_next;
    fmc_req_t req;
    logic     pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_CARRIER_INC: cfg_next.carrier_increment   = cfg_data;
                CFG_OUTER_INC:   cfg_next.outer_mod_increment = cfg_data;
                CFG_INNER_INC:   cfg_next.inner_mod_increment = cfg_data;
                CFG_OUTER_INDEX: cfg_next.outer_index         = cfg_data[INDEX_W-1:0];
                CFG_INNER_INDEX: cfg_next.inner_index         = cfg_data[INDEX_W-1:0];
                CFG_OUTPUT_GAIN: cfg_next.output_gain         = cfg_data[GAIN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    fmc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .note_start (note_start),
        .pop        (pop),
        .req        (req)
    );

    fmc_engine #(
        .PHASE_BITS (PHASE_BITS),
        .ADDR_BITS  (SINE_TABLE_ADDR_BITS)
    ) u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req        (req),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

endmodule
